// File: design/dmc_pkg.sv
// Package for the direct-mapped write-back cache.
// Holds request codes and the sequencer state type; no dependencies.
package dmc_pkg;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_WRITE  = 2'd2;
    localparam logic [1:0] REQ_SEARCH = 2'd3;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_TAG    = 10'b0000000010,
        ST_WBRD   = 10'b0000000100,
        ST_WBWR   = 10'b0000001000,
        ST_FILLRD = 10'b0000010000,
        ST_FILLWR = 10'b0000100000,
        ST_ACCESS = 10'b0001000000,
        ST_CSCAN  = 10'b0010000000,
        ST_SSCAN  = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } t_state;

endpackage

// File: design/direct_mapped_write_back_cache_top.sv
// Top level of the direct-mapped write-back cache: sequencer, cache arrays
// and backing store memory. Depends on dmc_pkg and dmc_cmp.
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_ready   i_req_type i_page_addr i_line_addr
//                                           i_word_addr i_data_in
//  response  out        o_valid / i_ready   o_read_value o_cache_hit o_match_*
//                                           o_found_in_store o_addr_error
//
// One transaction at a time. A load and an address error go straight to the
// response; a hit reads or writes the word; a miss into an empty line refills
// it first, and a miss with write-back first copies the old line out, one word
// at a time through the single-port store and word array. A search walks the
// cache words in order and stops at the first match; if none matches, it walks
// the store until a match or its end.
// Reset clears the line tags through valid bits; cache words read as zero
// until a line is filled. A waiting response holds until it is taken.
module direct_mapped_write_back_cache_top
    import dmc_pkg::*;
#(
    parameter int unsigned PAGES = 16,
    parameter int unsigned LINES = 16,
    parameter int unsigned WORDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [4:0]  i_page_addr,
    input  logic [4:0]  i_line_addr,
    input  logic [2:0]  i_word_addr,
    input  logic signed [15:0] i_data_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_read_value,
    output logic        o_cache_hit,
    output logic [4:0]  o_match_page,
    output logic [4:0]  o_match_line,
    output logic [2:0]  o_match_word,
    output logic        o_found_in_store,
    output logic        o_addr_error
);
    localparam int unsigned LW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int unsigned WW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int unsigned CD = LINES * WORDS;
    localparam int unsigned CW = (CD > 1) ? $clog2(CD) : 1;
    localparam int unsigned SD = PAGES * CD;
    localparam int unsigned SW = (SD > 1) ? $clog2(SD) : 1;
    localparam int unsigned CNW = $clog2(SD + 1);

    // Storage
    logic [15:0]   r_store [SD];
    logic [15:0]   r_cwords[CD];
    logic [7:0]    r_tags  [LINES];
    logic [LINES-1:0] r_lvalid;
    logic [CD-1:0]    r_wvalid;

    t_state r_state, n_state;
    logic [1:0]    r_req;
    logic [PW-1:0] r_page;
    logic [7:0]    r_pfull;
    logic [LW-1:0] r_line;
    logic [WW-1:0] r_word;
    logic [15:0]   r_data;
    logic [CNW-1:0] r_cnt;
    logic [7:0]    r_oldtag;
    logic [LW-1:0] r_sl, r_pl;
    logic [WW-1:0] r_sw, r_pw;

    logic [15:0]   r_srd, r_crd;
    logic [15:0]   r_rv;
    logic          r_hit, r_fs, r_err;
    logic [4:0]    r_mp, r_ml;
    logic [2:0]    r_mw;

    // Address checks
    logic addr_ok;
    assign addr_ok = (i_page_addr >= 5'd1) && (32'(i_page_addr) <= PAGES)
                  && (i_line_addr >= 5'd1) && (32'(i_line_addr) <= LINES)
                  && (i_word_addr >= 3'd1) && (32'(i_word_addr) <= WORDS);

    logic [7:0] cur_tag;
    assign cur_tag = r_lvalid[r_line] ? r_tags[r_line] : 8'd0;

    logic w_word_eq, w_tag_eq, w_tag_zero;
    logic [15:0] cmp_a;
    assign cmp_a = (r_state == ST_SSCAN) ? r_srd : r_crd;
    dmc_cmp #(.TW(8)) u_cmp (
        .i_a(cmp_a), .i_b(r_data), .i_tag(cur_tag), .i_page(r_pfull),
        .o_word_eq(w_word_eq), .o_tag_eq(w_tag_eq), .o_tag_zero(w_tag_zero)
    );

    // Address generation
    logic [WW-1:0] cnt_w;
    logic [CW-1:0] line_base, cidx, scan_cidx;
    logic [SW-1:0] wb_base, rf_base, sidx;
    assign cnt_w     = r_cnt[WW-1:0];
    assign line_base = CW'(r_line) * CW'(WORDS);
    assign wb_base   = (SW'(r_oldtag - 8'd1) * SW'(LINES) + SW'(r_line)) * SW'(WORDS);
    assign rf_base   = (SW'(r_page) * SW'(LINES) + SW'(r_line)) * SW'(WORDS);
    assign scan_cidx = r_cnt[CW-1:0];

    always_comb begin
        sidx = '0;
        cidx = line_base + CW'(r_word);
        case (r_state)
            ST_TAG, ST_WBRD: begin
                sidx = wb_base + SW'(cnt_w);
                cidx = line_base + CW'(cnt_w);
            end
            ST_WBWR: begin
                sidx = wb_base + SW'(cnt_w);
                cidx = line_base + CW'(cnt_w);
            end
            ST_FILLRD, ST_FILLWR: begin
                sidx = rf_base + SW'(cnt_w);
                cidx = line_base + CW'(cnt_w);
            end
            ST_CSCAN: cidx = scan_cidx;
            ST_SSCAN: sidx = r_cnt[SW-1:0];
            default: ;
        endcase
    end

    logic last_word;
    assign last_word = (32'(cnt_w) == WORDS - 1);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) begin
                if (i_req_type == REQ_SEARCH) n_state = ST_CSCAN;
                else if (!addr_ok || i_req_type == REQ_LOAD) n_state = ST_DONE;
                else n_state = ST_TAG;
            end
            ST_TAG:    n_state = w_tag_eq ? ST_ACCESS : (w_tag_zero ? ST_FILLRD : ST_WBRD);
            ST_WBRD:   n_state = ST_WBWR;
            ST_WBWR:   n_state = last_word ? ST_FILLRD : ST_WBRD;
            ST_FILLRD: n_state = ST_FILLWR;
            ST_FILLWR: n_state = last_word ? ST_ACCESS : ST_FILLRD;
            ST_ACCESS: n_state = ST_DONE;
            ST_CSCAN:  if (r_cnt != '0 && w_word_eq) n_state = ST_DONE;
                       else if (32'(r_cnt) == CD) n_state = ST_SSCAN;
            ST_SSCAN:  if ((r_cnt != '0 && w_word_eq) || 32'(r_cnt) == SD) n_state = ST_DONE;
            ST_DONE:   if (i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_lvalid <= '0;
            r_wvalid <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_TAG && !w_tag_eq) begin
                r_lvalid[r_line] <= 1'b1;
            end
            if (r_state == ST_FILLWR || (r_state == ST_ACCESS && r_req == REQ_WRITE)) begin
                r_wvalid[cidx] <= 1'b1;
            end
        end
    end

    // Datapath: memories and result
    logic [15:0] crd_now;
    assign crd_now = r_wvalid[cidx] ? r_cwords[cidx] : 16'd0;

    always_ff @(posedge i_clk) begin
        r_srd <= r_store[sidx];
        r_crd <= crd_now;
        case (r_state)
            ST_IDLE: if (i_valid) begin
                r_req   <= i_req_type;
                r_page  <= PW'(i_page_addr - 5'd1);
                r_pfull <= 8'(i_page_addr);
                r_line  <= LW'(i_line_addr - 5'd1);
                r_word  <= WW'(i_word_addr - 3'd1);
                r_data  <= i_data_in;
                r_cnt   <= '0;
                r_sl    <= '0;
                r_sw    <= '0;
                r_rv <= '0; r_hit <= 1'b0; r_fs <= 1'b0;
                r_mp <= '0; r_ml <= '0; r_mw <= '0;
                r_err <= (i_req_type != REQ_SEARCH) && !addr_ok;
                if (i_req_type == REQ_LOAD && addr_ok) begin
                    r_store[(SW'(i_page_addr - 5'd1) * SW'(LINES)
                             + SW'(i_line_addr - 5'd1)) * SW'(WORDS)
                             + SW'(i_word_addr - 3'd1)] <= i_data_in;
                end
            end
            ST_TAG: begin
                r_oldtag <= cur_tag;
                r_cnt    <= '0;
                if (w_tag_eq) r_hit <= 1'b1;
                else r_tags[r_line] <= r_pfull;
            end
            ST_WBWR: begin
                r_store[sidx] <= r_crd;
                r_cnt <= last_word ? '0 : r_cnt + 1'b1;
            end
            ST_FILLWR: begin
                r_cwords[cidx] <= r_srd;
                r_cnt <= r_cnt + 1'b1;
            end
            ST_ACCESS: begin
                if (r_req == REQ_WRITE) begin
                    r_cwords[cidx] <= r_data;
                    r_rv <= r_data;
                end else begin
                    r_rv <= crd_now;
                end
            end
            ST_CSCAN: begin
                // r_crd holds word r_cnt-1, whose line and word are r_pl and r_pw
                r_pl <= r_sl;
                r_pw <= r_sw;
                if (r_cnt != '0 && w_word_eq) begin
                    r_hit <= 1'b1;
                    r_mp  <= 5'(r_lvalid[r_pl] ? r_tags[r_pl] : 8'd0);
                    r_ml  <= 5'(r_pl) + 5'd1;
                    r_mw  <= 3'(r_pw) + 3'd1;
                end else if (32'(r_cnt) == CD) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    if (32'(r_sw) == WORDS - 1) begin
                        r_sw <= '0;
                        r_sl <= r_sl + 1'b1;
                    end else begin
                        r_sw <= r_sw + 1'b1;
                    end
                end
            end
            ST_SSCAN: begin
                if (r_cnt != '0 && w_word_eq) r_fs <= 1'b1;
                else r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = (r_state == ST_DONE);
    assign o_read_value     = r_rv;
    assign o_cache_hit      = r_hit;
    assign o_match_page     = r_mp;
    assign o_match_line     = r_ml;
    assign o_match_word     = r_mw;
    assign o_found_in_store = r_fs;
    assign o_addr_error     = r_err;

    // Assertions
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_addr_error |-> !o_cache_hit && o_read_value == 16'd0)
        else $error("error response carries data");
    a_hit_fs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_cache_hit && o_found_in_store))
        else $error("hit and store match together");
    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FILLWR && last_word |=> r_state == ST_ACCESS)
        else $error("refill did not end in access");
endmodule

// File: design/dmc_cmp.sv
// Shared compare unit of the cache sequencer: equality of a stored word
// with the search key, and of a line tag with the requested page and with zero. Uses dmc_pkg.
module dmc_cmp
    import dmc_pkg::*;
#(
    parameter int unsigned TW = 5
) (
    input  logic [15:0]   i_a,
    input  logic [15:0]   i_b,
    input  logic [TW-1:0] i_tag,
    input  logic [TW-1:0] i_page,
    output logic          o_word_eq,
    output logic          o_tag_eq,
    output logic          o_tag_zero
);
    // Compare the word pair and the tag pair, and test the tag for zero
    assign o_word_eq  = (i_a == i_b);
    assign o_tag_eq   = (i_tag == i_page);
    assign o_tag_zero = (i_tag == '0);
endmodule

// File: sim/cache_checker.sv
// Response checker for the direct-mapped write-back cache testbench.
// Watches both channels, keeps a shadow cache and store, and counts mismatches.
// Depends on dmc_pkg for the request codes.
`timescale 1ns / 100ps

module cache_checker
    import dmc_pkg::*;
#(
    parameter int unsigned PAGES = 16,
    parameter int unsigned LINES = 16,
    parameter int unsigned WORDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_req_type,
    input  logic [4:0]  i_page_addr,
    input  logic [4:0]  i_line_addr,
    input  logic [2:0]  i_word_addr,
    input  logic [15:0] i_data_in,
    input  logic        i_resp_valid,
    input  logic        i_resp_ready,
    input  logic [15:0] i_read_value,
    input  logic        i_cache_hit,
    input  logic [4:0]  i_match_page,
    input  logic [4:0]  i_match_line,
    input  logic [2:0]  i_match_word,
    input  logic        i_found_in_store,
    input  logic        i_addr_error,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] read_value;
        logic        cache_hit;
        logic [4:0]  match_page;
        logic [4:0]  match_line;
        logic [2:0]  match_word;
        logic        found_in_store;
        logic        addr_error;
    } t_resp;

    logic [4:0]  shadow_tags  [LINES];
    logic [15:0] shadow_words [LINES*WORDS];
    logic [15:0] shadow_store [PAGES*LINES*WORDS];
    t_resp       resp_queue   [$];

    // Compute one response and advance the shadow state
    task automatic model_request(input logic [1:0] rq, input logic [4:0] pg,
                                 input logic [4:0] ln, input logic [2:0] wd,
                                 input logic [15:0] dat, output t_resp r);
        bit found;
        int li;
        int wb;
        int rb;
        r = '0;
        found = 1'b0;
        if (rq == REQ_SEARCH) begin
            for (int i = 0; i < LINES && !found; i++) begin
                for (int j = 0; j < WORDS && !found; j++) begin
                    if (shadow_words[i*WORDS+j] == dat) begin
                        found = 1'b1;
                        r.cache_hit = 1'b1;
                        r.match_page = shadow_tags[i];
                        r.match_line = 5'(i + 1);
                        r.match_word = 3'(j + 1);
                    end
                end
            end
            if (!found) begin
                for (int i = 0; i < PAGES*LINES*WORDS; i++) begin
                    if (shadow_store[i] == dat) r.found_in_store = 1'b1;
                end
            end
        end else if (pg < 1 || pg > PAGES || ln < 1 || ln > LINES ||
                     wd < 1 || wd > WORDS) begin
            r.addr_error = 1'b1;
        end else if (rq == REQ_LOAD) begin
            shadow_store[((pg-1)*LINES + ln-1)*WORDS + wd-1] = dat;
        end else begin
            li = int'(ln) - 1;
            if (shadow_tags[li] == pg) begin
                r.cache_hit = 1'b1;
            end else begin
                // write back the old line, then refill
                if (shadow_tags[li] != 0) begin
                    wb = ((int'(shadow_tags[li]) - 1)*LINES + li)*WORDS;
                    for (int j = 0; j < WORDS; j++)
                        shadow_store[wb+j] = shadow_words[li*WORDS+j];
                end
                rb = ((int'(pg) - 1)*LINES + li)*WORDS;
                for (int j = 0; j < WORDS; j++)
                    shadow_words[li*WORDS+j] = shadow_store[rb+j];
                shadow_tags[li] = pg;
            end
            if (rq == REQ_WRITE) shadow_words[li*WORDS + wd-1] = dat;
            r.read_value = shadow_words[li*WORDS + wd-1];
        end
    endtask

    assign o_pending = resp_queue.size();

    // Clear on reset; predict on accepted requests, compare on accepted responses
    always @(posedge i_clk) begin
        t_resp want;
        t_resp got;
        if (!i_rst_n) begin
            o_errors = 0;
            resp_queue.delete();
            for (int i = 0; i < LINES; i++) shadow_tags[i] = '0;
            for (int i = 0; i < LINES*WORDS; i++) shadow_words[i] = '0;
            for (int i = 0; i < PAGES*LINES*WORDS; i++) shadow_store[i] = '0;
        end else begin
            if (i_resp_valid && i_resp_ready) begin
                got = {i_read_value, i_cache_hit, i_match_page, i_match_line,
                       i_match_word, i_found_in_store, i_addr_error};
                if (resp_queue.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected response %h", got);
                end else begin
                    want = resp_queue.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("mismatch: exp rv=%h hit=%b mp=%0d ml=%0d mw=%0d fs=%b err=%b",
                                     want.read_value, want.cache_hit, want.match_page,
                                     want.match_line, want.match_word,
                                     want.found_in_store, want.addr_error);
                            $display("          got rv=%h hit=%b mp=%0d ml=%0d mw=%0d fs=%b err=%b",
                                     got.read_value, got.cache_hit, got.match_page,
                                     got.match_line, got.match_word,
                                     got.found_in_store, got.addr_error);
                        end
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                model_request(i_req_type, i_page_addr, i_line_addr, i_word_addr,
                              i_data_in, want);
                resp_queue.push_back(want);
            end
        end
    end

endmodule

// File: sim/direct_mapped_write_back_cache_top_tb.sv
// Top of the cache testbench: clock, reset, request and response drivers.
// Depends on dmc_pkg, direct_mapped_write_back_cache_top and cache_checker.
`timescale 1ns / 100ps

module direct_mapped_write_back_cache_top_tb;
    import dmc_pkg::*;

    localparam int PAGES = 16;
    localparam int LINES = 16;
    localparam int WORDS = 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_req_type;
    logic [4:0]  i_page_addr;
    logic [4:0]  i_line_addr;
    logic [2:0]  i_word_addr;
    logic signed [15:0] i_data_in;
    logic        o_valid;
    logic        i_ready;
    logic signed [15:0] o_read_value;
    logic        o_cache_hit;
    logic [4:0]  o_match_page;
    logic [4:0]  o_match_line;
    logic [2:0]  o_match_word;
    logic        o_found_in_store;
    logic        o_addr_error;

    int mismatch_count;
    int pending_count;
    int type_count [4];
    bit no_gaps;
    bit long_hold_req;

    direct_mapped_write_back_cache_top #(
        .PAGES(PAGES), .LINES(LINES), .WORDS(WORDS)
    ) uut (.*);

    cache_checker #(.PAGES(PAGES), .LINES(LINES), .WORDS(WORDS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_req_type(i_req_type), .i_page_addr(i_page_addr),
        .i_line_addr(i_line_addr), .i_word_addr(i_word_addr),
        .i_data_in(i_data_in), .i_resp_valid(o_valid), .i_resp_ready(i_ready),
        .i_read_value(o_read_value), .i_cache_hit(o_cache_hit),
        .i_match_page(o_match_page), .i_match_line(o_match_line),
        .i_match_word(o_match_word), .i_found_in_store(o_found_in_store),
        .i_addr_error(o_addr_error), .o_errors(mismatch_count),
        .o_pending(pending_count)
    );

    // 8 ns clock, first rising edge after reset is driven
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Offer one transaction after a random gap unless no_gaps is set, hold until accepted
    task automatic send_request(input logic [1:0] rq, input logic [4:0] pg,
                                input logic [4:0] ln, input logic [2:0] wd,
                                input logic [15:0] dat);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= rq;
        i_page_addr <= pg;
        i_line_addr <= ln;
        i_word_addr <= wd;
        i_data_in   <= dat;
        type_count[rq]++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Pick a value that often repeats so searches can hit
    function automatic logic [15:0] pick_value();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
    endfunction

    // Pick an address field, mostly legal, sometimes out of range
    function automatic logic [4:0] pick_field(input int top, input int bits);
        if ($urandom_range(0, 19) == 0)
            return ($urandom_range(0, 1) == 0) ? 5'd0 :
                   5'($urandom_range(top + 1, (1 << bits) - 1));
        return 5'($urandom_range(1, top));
    endfunction

    task automatic wait_drained();
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Response side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 0;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 12);
            repeat (gap) begin
                i_ready <= 1'b0;
                @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Stimulus and verdict
    initial begin
        logic [1:0]  rq;
        logic [15:0] dat;
        int pick;
        i_valid       <= 1'b0;
        i_req_type    <= REQ_LOAD;
        i_page_addr   <= '0;
        i_line_addr   <= '0;
        i_word_addr   <= '0;
        i_data_in     <= '0;
        i_rst_n       <= 1'b0;
        no_gaps       = 1;
        long_hold_req = 0;
        for (int i = 0; i < 4; i++) type_count[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole store so refills and store scans read defined data
        for (int p = 1; p <= PAGES; p++)
            for (int l = 1; l <= LINES; l++)
                for (int w = 1; w <= WORDS; w++)
                    send_request(REQ_LOAD, 5'(p), 5'(l), 3'(w), pick_value());
        no_gaps = 0;

        // directed: miss into empty line, hit, write, eviction, extremes
        send_request(REQ_READ,  1, 1, 1, 16'h0000);
        send_request(REQ_READ,  1, 1, 4, 16'h0000);
        send_request(REQ_WRITE, 1, 1, 2, 16'h8000);
        send_request(REQ_WRITE, 16, 1, 3, 16'h7fff);
        send_request(REQ_READ,  1, 1, 2, 16'hffff);
        send_request(REQ_WRITE, 16, 16, 4, 16'hffff);
        // load into a cached line, then evict it so write-back wins
        send_request(REQ_LOAD,  1, 1, 2, 16'h1234);
        send_request(REQ_READ,  2, 1, 1, 16'h0000);
        send_request(REQ_READ,  1, 1, 2, 16'h0000);
        // searches: cache hit, zero in an empty line, store only, garbage addrs
        send_request(REQ_SEARCH, 0, 0, 0, 16'h7fff);
        send_request(REQ_SEARCH, 31, 31, 7, 16'h0000);
        send_request(REQ_SEARCH, 5, 9, 2, 16'h1234);
        send_request(REQ_SEARCH, 0, 17, 5, 16'h8000);
        send_request(REQ_SEARCH, 1, 1, 1, 16'h5a5a);
        // out-of-range addresses on every access type
        send_request(REQ_READ,  0, 1, 1, 16'h0000);
        send_request(REQ_WRITE, 17, 1, 1, 16'h5555);
        send_request(REQ_LOAD,  31, 1, 1, 16'haaaa);
        send_request(REQ_READ,  1, 0, 1, 16'h0000);
        send_request(REQ_WRITE, 1, 17, 1, 16'h5555);
        send_request(REQ_LOAD,  1, 31, 1, 16'haaaa);
        send_request(REQ_READ,  1, 1, 0, 16'h0000);
        send_request(REQ_WRITE, 1, 1, 5, 16'h5555);
        send_request(REQ_LOAD,  1, 1, 7, 16'haaaa);

        // pause until every response is back
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();

        // random traffic
        for (int n = 0; n < 400; n++) begin
            if (n == 60) long_hold_req = 1;
            if (n == 150) no_gaps = 1;
            if (n == 200) no_gaps = 0;
            pick = $urandom_range(0, 99);
            rq = (pick < 20) ? REQ_LOAD : (pick < 50) ? REQ_READ :
                 (pick < 82) ? REQ_WRITE : REQ_SEARCH;
            dat = pick_value();
            if (rq == REQ_SEARCH)
                send_request(rq, 5'($urandom), 5'($urandom), 3'($urandom), dat);
            else
                send_request(rq, pick_field(PAGES, 5), pick_field(LINES, 5),
                             3'(pick_field(WORDS, 3)), dat);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("covered %0d loads, %0d reads, %0d writes, %0d searches",
                 type_count[REQ_LOAD], type_count[REQ_READ],
                 type_count[REQ_WRITE], type_count[REQ_SEARCH]);
        $display("with random stalls on both sides and one long response hold-off");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("direct_mapped_write_back_cache_top_tb passed");
        end else begin
            $display("direct_mapped_write_back_cache_top_tb failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("direct_mapped_write_back_cache_top_tb failed");
        $finish;
    end

endmodule

// File: direct_mapped_write_back_cache_top.f
design/dmc_pkg.sv
design/dmc_cmp.sv
design/direct_mapped_write_back_cache_top.sv
sim/cache_checker.sv
sim/direct_mapped_write_back_cache_top_tb.sv
